### rtl/core/mfd_pkg.sv
package mfd_pkg;

   // frame geometry
   localparam int MAX_BODY       = 65536;
   localparam int HEADER_CHARS   = 10;
   localparam int CHECKSUM_BYTES = 8;

   localparam int LEN_W   = 17;
   localparam int PROD_W  = LEN_W + 4;
   localparam int HIDX_W  = 4;
   localparam int TIDX_W  = 3;
   localparam int SUM_W   = 64;
   localparam int CSUM_W  = 8 * CHECKSUM_BYTES;

   localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(MAX_BODY);

   // result kinds
   localparam logic [1:0] KIND_BODY  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // frame phases
   localparam logic [1:0] PH_TYPE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_BODY    = 2'd2;
   localparam logic [1:0] PH_TRAILER = 2'd3;

   // header number parser
   localparam logic [1:0] NP_SKIP   = 2'd0;
   localparam logic [1:0] NP_DIGITS = 2'd1;
   localparam logic [1:0] NP_DONE   = 2'd2;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       body_byte;
      logic [7:0]       type_byte;
      logic [LEN_W-1:0] body_length;
      logic             checksum_match;
      logic [SUM_W-1:0] received_sum;
      logic             frame_last;
   } rsp_type;

endpackage

### rtl/core/message_frame_deframer.sv
// latency: a result appears in the cycle after the request that causes it
// throughput: one byte per cycle; a held result only stalls the input while
//    rsp_stall is high
// reset (synchronous, active high) returns the parser to the type byte,
//    drops any held result and sets length_limit to 65536
module message_frame_deframer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [7:0]                        rsp_body_byte,
   output logic [7:0]                        rsp_type_byte,
   output logic [mfd_pkg::LEN_W-1:0]         rsp_body_length,
   output logic                              rsp_checksum_match,
   output logic [mfd_pkg::SUM_W-1:0]         rsp_received_sum,
   output logic                              rsp_frame_last,
   input  logic                              csr_wr_en,
   input  logic [mfd_pkg::LEN_W-1:0]         csr_wr_data
);
   import mfd_pkg::*;

   localparam logic [SUM_W-1:0]  CSUM_MASK  = {SUM_W{1'b1}} >> (SUM_W - CSUM_W);
   localparam logic [HIDX_W-1:0] HDR_LAST   = HIDX_W'(HEADER_CHARS);
   localparam logic [TIDX_W:0]   TRL_COUNT  = (TIDX_W+1)'(CHECKSUM_BYTES);
   localparam logic [PROD_W-1:0] MAX_WIDE   = PROD_W'(MAX_BODY);
   localparam logic [LEN_W-1:0]  MAX_NARROW = LEN_W'(MAX_BODY);

   logic [LEN_W-1:0]  limit_ff;
   logic [1:0]        phase_ff, phase_in;
   logic [HIDX_W-1:0] hidx_ff, hidx_in;
   logic [1:0]        np_ff, np_in;
   logic              neg_ff, neg_in;
   logic [LEN_W-1:0]  acc_ff, acc_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        type_ff, type_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [LEN_W-1:0]  blen_ff, blen_in;
   logic [SUM_W-1:0]  bsum_ff, bsum_in;
   logic [SUM_W-1:0]  trl_ff, trl_in;
   logic [TIDX_W-1:0] tidx_ff, tidx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              load;
   logic              produce;
   logic [7:0]        b;
   logic              consumed;
   logic              is_space;
   logic              is_digit;
   logic [PROD_W-1:0] prod;
   logic              len_error;

   assign b         = req_data_byte;
   assign load      = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !load;
   assign accept    = req_valid && load;

   assign is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   assign is_digit = (b >= 8'h30 && b <= 8'h39);
   // acc * 10 + digit
   assign prod = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
               + PROD_W'(b - 8'h30);

   always_comb begin
      phase_in  = phase_ff;
      hidx_in   = hidx_ff;
      np_in     = np_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      type_in   = type_ff;
      remain_in = remain_ff;
      blen_in   = blen_ff;
      bsum_in   = bsum_ff;
      trl_in    = trl_ff;
      tidx_in   = tidx_ff;
      consumed  = 1'b0;
      len_error = 1'b0;
      produce   = 1'b0;
      rsp_in    = '0;

      case (phase_ff)
         PH_TYPE: begin
            type_in  = b;
            phase_in = PH_HEADER;
            hidx_in  = '0;
            np_in    = NP_SKIP;
            neg_in   = 1'b0;
            acc_in   = '0;
            ovf_in   = 1'b0;
            bsum_in  = '0;
         end
         PH_HEADER: begin
            if (np_ff != NP_DONE && b == 8'h00) begin
               np_in = NP_DONE;
            end else begin
               if (np_ff == NP_SKIP) begin
                  if (is_space) begin
                     consumed = 1'b1;
                  end else begin
                     np_in = NP_DIGITS;
                     if (b == 8'h2B) begin
                        consumed = 1'b1;
                     end else if (b == 8'h2D) begin
                        neg_in   = 1'b1;
                        consumed = 1'b1;
                     end
                  end
               end
               if (!consumed && np_in == NP_DIGITS) begin
                  if (is_digit) begin
                     if (!ovf_ff) begin
                        if (prod > MAX_WIDE) begin
                           ovf_in = 1'b1;
                           acc_in = MAX_NARROW;
                        end else begin
                           acc_in = prod[LEN_W-1:0];
                        end
                     end
                  end else begin
                     np_in = NP_DONE;
                  end
               end
            end
            hidx_in = hidx_ff + 1'b1;
            if (hidx_in >= HDR_LAST) begin
               len_error = ovf_in || (neg_in && acc_in != '0) || (acc_in > limit_ff);
               if (len_error) begin
                  phase_in         = PH_TYPE;
                  produce          = 1'b1;
                  rsp_in.kind      = KIND_ERROR;
                  rsp_in.type_byte = type_ff;
                  rsp_in.frame_last = 1'b1;
               end else begin
                  blen_in   = acc_in;
                  remain_in = acc_in;
                  if (acc_in == '0) begin
                     phase_in = PH_TRAILER;
                     trl_in   = '0;
                     tidx_in  = '0;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
         end
         PH_BODY: begin
            bsum_in   = bsum_ff + {{(SUM_W-8){b[7]}}, b};
            remain_in = remain_ff - 1'b1;
            if (remain_ff == LEN_W'(1)) begin
               phase_in = PH_TRAILER;
               trl_in   = '0;
               tidx_in  = '0;
            end
            produce            = 1'b1;
            rsp_in.kind        = KIND_BODY;
            rsp_in.body_byte   = b;
            rsp_in.type_byte   = type_ff;
            rsp_in.body_length = blen_ff;
         end
         PH_TRAILER: begin
            trl_in = trl_ff;
            trl_in[{tidx_ff, 3'b000} +: 8] = b;
            tidx_in = tidx_ff + 1'b1;
            if (tidx_in == '0 || {1'b0, tidx_in} >= TRL_COUNT) begin
               phase_in              = PH_TYPE;
               tidx_in               = '0;
               produce               = 1'b1;
               rsp_in.kind           = KIND_END;
               rsp_in.type_byte      = type_ff;
               rsp_in.body_length    = blen_ff;
               rsp_in.checksum_match = (trl_in == (bsum_ff & CSUM_MASK));
               rsp_in.received_sum   = trl_in;
               rsp_in.frame_last     = 1'b1;
            end
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase
   end

   assign rsp_valid_in = load ? (accept && produce) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         phase_ff     <= PH_TYPE;
         hidx_ff      <= '0;
         np_ff        <= NP_SKIP;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         type_ff      <= '0;
         remain_ff    <= '0;
         blen_ff      <= '0;
         bsum_ff      <= '0;
         trl_ff       <= '0;
         tidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff  <= phase_in;
            hidx_ff   <= hidx_in;
            np_ff     <= np_in;
            neg_ff    <= neg_in;
            acc_ff    <= acc_in;
            ovf_ff    <= ovf_in;
            type_ff   <= type_in;
            remain_ff <= remain_in;
            blen_ff   <= blen_in;
            bsum_ff   <= bsum_in;
            trl_ff    <= trl_in;
            tidx_ff   <= tidx_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && produce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_body_byte      = rsp_ff.body_byte;
   assign rsp_type_byte      = rsp_ff.type_byte;
   assign rsp_body_length    = rsp_ff.body_length;
   assign rsp_checksum_match = rsp_ff.checksum_match;
   assign rsp_received_sum   = rsp_ff.received_sum;
   assign rsp_frame_last     = rsp_ff.frame_last;

   // a type byte never yields a result
   a_type_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_TYPE) |=> !rsp_valid_ff)
      else $error("result after type byte");

   a_body_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_BODY) |-> !rsp_ff.frame_last)
      else $error("body result marked last");

   a_body_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (remain_ff != '0))
      else $error("body phase with nothing left");

   a_trailer_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TRAILER) |-> ({1'b0, tidx_ff} < TRL_COUNT))
      else $error("checksum index out of range");

   a_header_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (hidx_ff < HDR_LAST))
      else $error("header index out of range");

endmodule

### tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES         = 6;
   localparam int PHASE_BYTES    = 275;

   typedef enum int {SUM_GOOD, SUM_FLIP, SUM_RANDOM, SUM_ONES} sum_style_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_kind;
   logic [7:0]          rsp_body_byte;
   logic [7:0]          rsp_type_byte;
   logic [LEN_W-1:0]    rsp_body_length;
   logic                rsp_checksum_match;
   logic [SUM_W-1:0]    rsp_received_sum;
   logic                rsp_frame_last;
   logic                csr_wr_en = 1'b0;
   logic [LEN_W-1:0]    csr_wr_data = '0;

   // deframer state as the stream should leave it
   logic [1:0]          fr_phase = PH_TYPE;
   logic [3:0]          hdr_count = '0;
   logic [1:0]          num_state = NP_SKIP;
   logic                num_negative = 1'b0;
   logic                num_overflow = 1'b0;
   logic [LEN_W-1:0]    num_value = '0;
   logic [LEN_W-1:0]    body_left = '0;
   logic [LEN_W-1:0]    body_len = '0;
   logic [LEN_W-1:0]    limit_model = LIMIT_RESET;
   logic [7:0]          cur_type = '0;
   logic [SUM_W-1:0]    body_total = '0;
   logic [SUM_W-1:0]    sum_received = '0;
   logic [TIDX_W-1:0]   sum_index = '0;

   rsp_type             deframed_q[$];
   rsp_type             oldest;
   logic [7:0]          byte_stream_q[$];
   logic [7:0]          frame_buf[$];

   int unsigned         bytes_queued = 0;
   int unsigned         mismatches = 0;
   int unsigned         quiet_cycles = 0;
   int unsigned         gap_max = 0;
   int unsigned         stall_max = 0;
   int unsigned         send_wait = 0;
   int unsigned         stall_left = 0;
   int unsigned         stall_draw;
   int unsigned         phase_start;
   int unsigned         pick;
   int unsigned         phase_limit[PHASES];
   int unsigned         phase_gap[PHASES];
   int unsigned         phase_stall[PHASES];

   message_frame_deframer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_body_byte      (rsp_body_byte),
      .rsp_type_byte      (rsp_type_byte),
      .rsp_body_length    (rsp_body_length),
      .rsp_checksum_match (rsp_checksum_match),
      .rsp_received_sum   (rsp_received_sum),
      .rsp_frame_last     (rsp_frame_last),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic deframe_byte(input logic [7:0] b);
      rsp_type     r;
      bit          emit;
      bit          consumed;
      bit          is_blank;
      bit          is_digit;
      int unsigned acc;
      r = '0;
      emit = 1'b0;
      consumed = 1'b0;
      is_blank = b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
      is_digit = b >= 8'h30 && b <= 8'h39;
      case (fr_phase)
         PH_TYPE: begin
            cur_type = b;
            fr_phase = PH_HEADER;
            hdr_count = '0;
            num_state = NP_SKIP;
            num_negative = 1'b0;
            num_value = '0;
            num_overflow = 1'b0;
            body_total = '0;
         end
         PH_HEADER: begin
            if (num_state != NP_DONE && b == 8'h00) begin
               num_state = NP_DONE;
            end else begin
               if (num_state == NP_SKIP && !is_blank) begin
                  num_state = NP_DIGITS;
                  if (b == 8'h2b) begin
                     consumed = 1'b1;
                  end else if (b == 8'h2d) begin
                     num_negative = 1'b1;
                     consumed = 1'b1;
                  end
               end
               if (num_state == NP_DIGITS && !consumed) begin
                  if (!is_digit) begin
                     num_state = NP_DONE;
                  end else if (!num_overflow) begin
                     acc = int'(num_value) * 10 + int'(b) - 48;
                     // saturate once the number runs past the largest body
                     if (acc > MAX_BODY) begin
                        num_overflow = 1'b1;
                        num_value = LEN_W'(MAX_BODY);
                     end else begin
                        num_value = LEN_W'(acc);
                     end
                  end
               end
            end
            hdr_count = hdr_count + 1'b1;
            if (hdr_count == HEADER_CHARS) begin
               if (num_overflow || (num_negative && num_value != 0) ||
                   num_value > limit_model) begin
                  fr_phase = PH_TYPE;
                  r.kind = KIND_ERROR;
                  r.type_byte = cur_type;
                  r.frame_last = 1'b1;
                  emit = 1'b1;
               end else begin
                  body_len = num_value;
                  body_left = num_value;
                  if (num_value == 0) begin
                     fr_phase = PH_TRAILER;
                     sum_received = '0;
                     sum_index = '0;
                  end else begin
                     fr_phase = PH_BODY;
                  end
               end
            end
         end
         PH_BODY: begin
            body_total = body_total + {{(SUM_W-8){b[7]}}, b};
            body_left = body_left - 1'b1;
            if (body_left == 0) begin
               fr_phase = PH_TRAILER;
               sum_received = '0;
               sum_index = '0;
            end
            r.kind = KIND_BODY;
            r.body_byte = b;
            r.type_byte = cur_type;
            r.body_length = body_len;
            emit = 1'b1;
         end
         PH_TRAILER: begin
            sum_received = sum_received | (SUM_W'(b) << (8 * sum_index));
            sum_index = sum_index + 1'b1;
            if (sum_index == 0 || sum_index >= CHECKSUM_BYTES) begin
               r.kind = KIND_END;
               r.type_byte = cur_type;
               r.body_length = body_len;
               r.checksum_match =
                  sum_received == (body_total & ((SUM_W'(1) << CSUM_W) - 1'b1));
               r.received_sum = sum_received;
               r.frame_last = 1'b1;
               emit = 1'b1;
               fr_phase = PH_TYPE;
               sum_index = '0;
            end
         end
         default: ;
      endcase
      if (emit)
         deframed_q.push_back(r);
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (byte_stream_q.size() != 0) begin
            req_valid <= 1'b1;
            req_data_byte <= byte_stream_q.pop_front();
            send_wait <= $urandom_range(0, gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor, prediction, stall and watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (deframed_q.size() == 0) begin
               $error("result with nothing expected: kind %0d", rsp_kind);
               mismatches++;
            end else begin
               oldest = deframed_q.pop_front();
               check_field("kind", oldest.kind, rsp_kind);
               check_field("body_byte", oldest.body_byte, rsp_body_byte);
               check_field("type_byte", oldest.type_byte, rsp_type_byte);
               check_field("body_length", oldest.body_length, rsp_body_length);
               check_field("checksum_match", oldest.checksum_match, rsp_checksum_match);
               check_field("received_sum", oldest.received_sum, rsp_received_sum);
               check_field("frame_last", oldest.frame_last, rsp_frame_last);
            end
         end
         if (req_valid && !req_stall)
            deframe_byte(req_data_byte);

         if (rsp_valid && !rsp_stall) begin
            stall_draw = $urandom_range(0, stall_max);
            stall_left <= stall_draw;
            rsp_stall <= stall_draw != 0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= stall_left > 1;
         end else if (stall_max != 0 && $urandom_range(0, 15) == 0) begin
            // occasional stall with no result waiting
            stall_draw = $urandom_range(1, stall_max);
            stall_left <= stall_draw;
            rsp_stall <= 1'b1;
         end

         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic logic [7:0] blank_char();
      int unsigned sel;
      sel = $urandom_range(0, 5);
      return sel == 5 ? 8'h20 : 8'(8'h09 + sel);
   endfunction

   // type byte plus a header that reads as the given number
   task automatic start_frame(input logic [7:0] kind_byte, input int unsigned value,
                              input bit negative, input bit no_digits);
      string       digits;
      int unsigned lead;
      int unsigned blanks;
      bit          all_blank;
      frame_buf = {};
      frame_buf.push_back(kind_byte);
      digits = no_digits ? "" : $sformatf("%0d", value);
      lead = $urandom_range(0, HEADER_CHARS - 1 - digits.len());
      blanks = no_digits ? lead : $urandom_range(0, lead);
      repeat (blanks) frame_buf.push_back(blank_char());
      if (negative)
         frame_buf.push_back(8'h2d);
      else if ($urandom_range(0, 2) == 0)
         frame_buf.push_back(8'h2b);
      repeat (lead - blanks) frame_buf.push_back(8'h30);
      for (int i = 0; i < digits.len(); i++)
         frame_buf.push_back(digits[i]);
      all_blank = no_digits && !negative && $urandom_range(0, 3) == 0;
      // the terminator must not be read as a digit or a sign
      if (frame_buf.size() <= HEADER_CHARS && !all_blank)
         case ($urandom_range(0, 3))
            0: frame_buf.push_back(8'h00);
            1: frame_buf.push_back(no_digits ? 8'h5f : blank_char());
            2: frame_buf.push_back(8'($urandom_range(8'h3a, 8'h7e)));
            default: frame_buf.push_back(8'($urandom_range(8'h80, 8'hff)));
         endcase
      while (frame_buf.size() <= HEADER_CHARS)
         frame_buf.push_back(all_blank ? blank_char() : 8'($urandom));
   endtask

   task automatic build_tail(input int unsigned len, input sum_style_type style);
      logic [SUM_W-1:0] total;
      logic [7:0]       b;
      total = '0;
      repeat (len) begin
         b = 8'($urandom);
         frame_buf.push_back(b);
         total = total + {{(SUM_W-8){b[7]}}, b};
      end
      case (style)
         SUM_FLIP:   total = total ^ (SUM_W'(1) << $urandom_range(0, SUM_W - 1));
         SUM_RANDOM: total = {$urandom, $urandom};
         SUM_ONES:   total = '1;
         default: ;
      endcase
      for (int i = 0; i < CHECKSUM_BYTES; i++)
         frame_buf.push_back(total[8*i +: 8]);
   endtask

   task automatic build_random_frame();
      int unsigned sel;
      int unsigned cap;
      int unsigned len;
      int unsigned top;
      logic [7:0]  kind_byte;
      sel = $urandom_range(0, 99);
      kind_byte = $urandom_range(0, 9) == 0 ? {8{sel[0]}} : 8'($urandom);
      cap = limit_model < 80 ? limit_model : 80;
      if (sel < 8) begin
         start_frame(kind_byte, $urandom_range(1, 99999), 1'b1, 1'b0);
      end else if (sel < 14) begin
         start_frame(kind_byte, $urandom_range(MAX_BODY + 1, 999999999), sel[0], 1'b0);
      end else if (sel < 20 && limit_model < MAX_BODY) begin
         top = limit_model + 300 > MAX_BODY ? MAX_BODY : limit_model + 300;
         start_frame(kind_byte, $urandom_range(limit_model + 1, top), 1'b0, 1'b0);
      end else begin
         if (sel < 27) begin
            len = 0;
            start_frame(kind_byte, 0, sel[0], 1'b1);
         end else begin
            if (sel < 75)
               len = $urandom_range(0, cap < 12 ? cap : 12);
            else if (sel < 95)
               len = $urandom_range(0, cap);
            else
               len = cap;
            start_frame(kind_byte, len, len == 0 && sel[0], 1'b0);
         end
         build_tail(len, $urandom_range(0, 9) < 7 ? SUM_GOOD :
                         sum_style_type'($urandom_range(SUM_FLIP, SUM_ONES)));
      end
   endtask

   task automatic emit_frame(input int keep);
      for (int i = 0; i < frame_buf.size() && (keep < 0 || i < keep); i++) begin
         byte_stream_q.push_back(frame_buf[i]);
         bytes_queued++;
      end
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (byte_stream_q.size() != 0 || req_valid || deframed_q.size() != 0);
   endtask

   // feed filler until the deframer is back at a type byte
   task automatic realign();
      wait_idle();
      while (fr_phase != PH_TYPE) begin
         frame_buf = {};
         repeat (fr_phase == PH_BODY ? body_left : 1) frame_buf.push_back(8'($urandom));
         emit_frame(-1);
         wait_idle();
      end
   endtask

   task automatic write_limit(input logic [LEN_W-1:0] value);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_model = value;
      @(negedge clock);
   endtask

   initial begin
      phase_limit = '{MAX_BODY, 0, 1, MAX_BODY - 1, 0, MAX_BODY};
      phase_limit[4] = $urandom_range(2, 200);
      phase_gap = '{17, 0, 17, 0, 5, 17};
      phase_stall = '{17, 0, 0, 17, 3, 17};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      gap_max = 2;
      stall_max = 2;
      // minus zero is length zero, straight to an all-ones checksum
      start_frame(8'hff, 0, 1'b1, 1'b0);
      build_tail(0, SUM_ONES);
      emit_frame(-1);
      start_frame(8'h5a, 7, 1'b1, 1'b0);
      emit_frame(-1);
      start_frame(8'h00, 999999999, 1'b0, 1'b0);
      emit_frame(-1);

      for (int p = 0; p < PHASES; p++) begin
         write_limit(LEN_W'(phase_limit[p]));
         gap_max = phase_gap[p];
         stall_max = phase_stall[p];
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               frame_buf = {};
               repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
               emit_frame(-1);
               realign();
            end else if (pick < 12) begin
               build_random_frame();
               emit_frame($urandom_range(1, frame_buf.size() - 1));
               realign();
            end else begin
               build_random_frame();
               emit_frame(-1);
            end
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
